### design/escape_string_decoder_unit_macros.svh
// Assertion macros for the escape string decoder.
// Both macros sample on the rising edge of clock and are disabled during reset.
`ifndef ESCAPE_STRING_DECODER_UNIT_MACROS_SVH
`define ESCAPE_STRING_DECODER_UNIT_MACROS_SVH

`define ESD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

`define ESD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/esd_pkg.sv
package esd_pkg;

   localparam int CHAR_W = 8;
   localparam int NUM_W = 9;
   localparam int ESD_QUEUE_DEPTH = 4;

   localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_NL = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_QUOTE = 8'h22;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_AT = 8'h40;
   localparam logic [CHAR_W-1:0] CHAR_BSLASH = 8'h5C;
   localparam logic [CHAR_W-1:0] CHAR_CARET = 8'h5E;
   localparam logic [CHAR_W-1:0] CHAR_USCORE = 8'h5F;
   localparam logic [CHAR_W-1:0] CHAR_LA = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LZ = 8'h7A;
   localparam logic [CHAR_W-1:0] CTRL_MASK = 8'h1F;
   localparam logic [CHAR_W-1:0] BYTE_MAX = 8'hFF;
   localparam logic [NUM_W-1:0] NUM_SAT = 9'd256;

   typedef enum logic [2:0] {
      MODE_NORMAL,
      MODE_ESCAPE,
      MODE_CARET,
      MODE_QUOTE,
      MODE_QCLOSE,
      MODE_NUMBER
   } mode_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic end_mark;
      logic number_error;
   } result_type;

   typedef struct packed {
      result_type first;
      logic has_second;
      result_type second;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### design/esd_if.sv
interface esd_req_if import esd_pkg::*; ();
   logic valid;
   logic ready;
   logic [CHAR_W-1:0] in_char;

   modport source (output valid, output in_char, input ready);
   modport sink (input valid, input in_char, output ready);
endinterface

interface esd_rsp_if import esd_pkg::*; ();
   logic valid;
   logic ready;
   logic [CHAR_W-1:0] out_char;
   logic end_mark;
   logic number_error;

   modport source (output valid, output out_char, output end_mark, output number_error,
                   input ready);
   modport sink (input valid, input out_char, input end_mark, input number_error,
                 output ready);
endinterface

### design/esd_front.sv
module esd_front import esd_pkg::*; (
   input  logic clock,
   input  logic reset,
   esd_req_if.sink req_bus,
   input  queue_status_type queue_status,
   output logic push,
   output entry_type push_entry
);

   mode_type mode_ff, mode_in;
   logic [NUM_W-1:0] number_ff, number_in;
   logic [CHAR_W-1:0] c;
   logic accept;
   logic is_digit;
   logic [CHAR_W-1:0] digit;
   logic [NUM_W+3:0] number_next;
   logic plain_emit;
   result_type plain_res;
   logic num_emit;
   result_type num_res;
   logic any_emit;
   result_type single_res;

   assign c = req_bus.in_char;
   assign req_bus.ready = !queue_status.full;
   assign accept = req_bus.valid && req_bus.ready;
   assign is_digit = c inside {[CHAR_ZERO:CHAR_NINE]};
   assign digit = c - CHAR_ZERO;
   assign number_next = ({4'd0, number_ff} << 3) + ({4'd0, number_ff} << 1)
                        + {{(NUM_W-4){1'b0}}, digit};

   function automatic mode_type plain_mode(input logic [CHAR_W-1:0] ch);
      mode_type m;
      m = MODE_NORMAL;
      if (ch == CHAR_BSLASH) begin
         m = MODE_ESCAPE;
      end else if (ch == CHAR_CARET) begin
         m = MODE_CARET;
      end else if (ch == CHAR_QUOTE) begin
         m = MODE_QUOTE;
      end else if (ch inside {[CHAR_ZERO:CHAR_NINE]}) begin
         m = MODE_NUMBER;
      end
      return m;
   endfunction

   always_comb begin
      mode_in = mode_ff;
      number_in = number_ff;
      case (mode_ff)
         MODE_ESCAPE, MODE_CARET: begin
            mode_in = MODE_NORMAL;
         end
         MODE_QUOTE: begin
            if (c == CHAR_NUL) begin
               mode_in = MODE_NORMAL;
            end else if (c == CHAR_QUOTE) begin
               mode_in = MODE_QCLOSE;
            end
         end
         MODE_QCLOSE: begin
            if (c == CHAR_QUOTE) begin
               mode_in = MODE_QUOTE;
            end else begin
               mode_in = plain_mode(c);
               number_in = is_digit ? {1'b0, digit} : '0;
            end
         end
         MODE_NUMBER: begin
            if (is_digit) begin
               number_in = (number_next > {4'd0, NUM_SAT}) ? NUM_SAT
                                                            : number_next[NUM_W-1:0];
            end else begin
               mode_in = plain_mode(c);
               number_in = '0;
            end
         end
         default: begin
            mode_in = plain_mode(c);
            number_in = is_digit ? {1'b0, digit} : '0;
         end
      endcase
   end

   always_comb begin
      plain_emit = 1'b0;
      plain_res = '0;
      if (c == CHAR_NUL || c == CHAR_NL) begin
         plain_emit = 1'b1;
         plain_res.end_mark = 1'b1;
      end else if (!(c inside {CHAR_SPACE, CHAR_TAB, CHAR_BSLASH, CHAR_CARET, CHAR_QUOTE})
                   && !is_digit) begin
         plain_emit = 1'b1;
         plain_res.out_char = c;
      end
   end

   always_comb begin
      num_emit = 1'b0;
      num_res = '0;
      single_res = '0;
      any_emit = 1'b0;
      case (mode_ff)
         MODE_ESCAPE: begin
            any_emit = 1'b1;
            if (c == CHAR_NUL) begin
               single_res.end_mark = 1'b1;
            end else begin
               single_res.out_char = c;
            end
         end
         MODE_CARET: begin
            if (c == CHAR_NUL) begin
               any_emit = 1'b1;
               single_res.end_mark = 1'b1;
            end else if ((c inside {[CHAR_AT:CHAR_USCORE], [CHAR_LA:CHAR_LZ]})
                         && ((c & CTRL_MASK) != CHAR_NUL)) begin
               any_emit = 1'b1;
               single_res.out_char = c & CTRL_MASK;
            end
         end
         MODE_QUOTE: begin
            if (c == CHAR_NUL) begin
               any_emit = 1'b1;
               single_res.end_mark = 1'b1;
            end else if (c != CHAR_QUOTE) begin
               any_emit = 1'b1;
               single_res.out_char = c;
            end
         end
         MODE_QCLOSE: begin
            if (c == CHAR_QUOTE) begin
               any_emit = 1'b1;
               single_res.out_char = CHAR_QUOTE;
            end else begin
               any_emit = plain_emit;
               single_res = plain_res;
            end
         end
         MODE_NUMBER: begin
            if (!is_digit) begin
               if (number_ff > {1'b0, BYTE_MAX}) begin
                  num_emit = 1'b1;
                  num_res.number_error = 1'b1;
               end else if (number_ff != '0) begin
                  num_emit = 1'b1;
                  num_res.out_char = number_ff[CHAR_W-1:0];
               end
               any_emit = num_emit || plain_emit;
               single_res = plain_res;
            end
         end
         default: begin
            any_emit = plain_emit;
            single_res = plain_res;
         end
      endcase
   end

   always_comb begin
      push = accept && any_emit;
      if (num_emit) begin
         push_entry.first = num_res;
         push_entry.has_second = plain_emit;
         push_entry.second = plain_res;
      end else begin
         push_entry.first = single_res;
         push_entry.has_second = 1'b0;
         push_entry.second = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         number_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         number_ff <= number_in;
      end
   end

endmodule

### design/esd_queue.sv
module esd_queue import esd_pkg::*; #(
   parameter int DEPTH = ESD_QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  entry_type push_entry,
   input  logic pop,
   output entry_type head,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

   entry_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign status.full = (count_ff == FULL_COUNT);
   assign status.empty = (count_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop = pop && !status.empty;
   assign head = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_ONE;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_ONE;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + ONE;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### design/esd_back.sv
module esd_back import esd_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  entry_type head,
   input  queue_status_type queue_status,
   output logic pop,
   esd_rsp_if.source rsp_bus
);

   logic half_ff, half_in;
   logic deliver;
   result_type current;

   assign current = half_ff ? head.second : head.first;
   assign rsp_bus.valid = !queue_status.empty;
   assign rsp_bus.out_char = current.out_char;
   assign rsp_bus.end_mark = current.end_mark;
   assign rsp_bus.number_error = current.number_error;
   assign deliver = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      pop = 1'b0;
      half_in = half_ff;
      if (deliver) begin
         if (half_ff || !head.has_second) begin
            pop = 1'b1;
            half_in = 1'b0;
         end else begin
            half_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= 1'b0;
      end else begin
         half_ff <= half_in;
      end
   end

endmodule

### design/escape_string_decoder_unit.sv
// Decodes a write-string one raw character per item into output bytes or
// number errors, closing each string with an end-marker item. A character is
// accepted every cycle while the result queue has room; its results are held
// in that queue for the response channel. A two-result character fills one
// entry that goes out as two items. That happens when a nonzero digit run is
// closed by a character that gives a result of its own, such as any other
// byte that passes through, a line end or a null. The front decoder stalls
// only when all QUEUE_DEPTH queue entries are waiting on the response side.
module escape_string_decoder_unit import esd_pkg::*; #(
   parameter int QUEUE_DEPTH = ESD_QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   esd_req_if.sink req_bus,
   esd_rsp_if.source rsp_bus
);

   logic push;
   logic pop;
   entry_type push_entry;
   entry_type head;
   queue_status_type queue_status;

   esd_front u_front (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .queue_status(queue_status),
      .push(push),
      .push_entry(push_entry)
   );

   esd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_entry(push_entry),
      .pop(pop),
      .head(head),
      .status(queue_status)
   );

   esd_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .queue_status(queue_status),
      .pop(pop),
      .rsp_bus(rsp_bus)
   );

endmodule

### design/esd_checker.sv
`include "escape_string_decoder_unit_macros.svh"

module esd_checker import esd_pkg::*; (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [CHAR_W-1:0] out_char,
   input logic end_mark,
   input logic number_error
);

   `ESD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(out_char) && $stable(end_mark) && $stable(number_error), "Stalled response item changed.")
   `ESD_ASSERT_ALWAYS(a_end_clean, !(rsp_valid && end_mark) || (out_char == CHAR_NUL && !number_error), "End marker carries data.")
   `ESD_ASSERT_ALWAYS(a_error_clean, !(rsp_valid && number_error) || (out_char == CHAR_NUL && !end_mark), "Number error carries data.")
   `ESD_ASSERT_ALWAYS(a_data_nonzero, !(rsp_valid && !end_mark && !number_error) || (out_char != CHAR_NUL), "Data item holds a null byte.")
   `ESD_ASSERT_ALWAYS(a_reset_empty, !$past(reset) || !rsp_valid, "Response valid right after reset.")

endmodule

bind escape_string_decoder_unit esd_checker u_esd_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .out_char(rsp_bus.out_char),
   .end_mark(rsp_bus.end_mark),
   .number_error(rsp_bus.number_error)
);

### tb/sv/tb_top.sv
module tb_top import esd_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic typed;
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } stim_row_type;

   localparam result_type NO_RES = '0;
   localparam result_type END_RES = '{out_char: CHAR_NUL, end_mark: 1'b1, number_error: 1'b0};
   localparam result_type ERR_RES = '{out_char: CHAR_NUL, end_mark: 1'b0, number_error: 1'b1};

   function automatic result_type byte_res(input logic [CHAR_W-1:0] b);
      return '{out_char: b, end_mark: 1'b0, number_error: 1'b0};
   endfunction

   function automatic stim_row_type pred_row(input logic [CHAR_W-1:0] c);
      return '{ch: c, typed: 1'b0, count: 2'd0, r0: NO_RES, r1: NO_RES};
   endfunction

   function automatic stim_row_type fixed_row(input logic [CHAR_W-1:0] c, input logic [1:0] n,
                                              input result_type a, input result_type b);
      return '{ch: c, typed: 1'b1, count: n, r0: a, r1: b};
   endfunction

   localparam int N_DIRECTED = 30;
   localparam stim_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      fixed_row("A", 2'd1, byte_res("A"), NO_RES),
      fixed_row(CHAR_SPACE, 2'd0, NO_RES, NO_RES),
      fixed_row(BYTE_MAX, 2'd1, byte_res(BYTE_MAX), NO_RES),
      pred_row(CHAR_CARET),
      fixed_row("X", 2'd1, byte_res(8'd24), NO_RES),
      pred_row(CHAR_CARET),
      pred_row(CHAR_AT),
      pred_row(CHAR_CARET),
      pred_row("1"),
      pred_row(CHAR_BSLASH),
      fixed_row(CHAR_NUL, 2'd1, END_RES, NO_RES),
      pred_row(CHAR_QUOTE),
      pred_row(CHAR_NL),
      pred_row(CHAR_QUOTE),
      pred_row(CHAR_QUOTE),
      fixed_row(CHAR_NUL, 2'd1, END_RES, NO_RES),
      pred_row(CHAR_QUOTE),
      pred_row("q"),
      pred_row(CHAR_QUOTE),
      pred_row("2"),
      pred_row("5"),
      pred_row("6"),
      fixed_row("x", 2'd2, ERR_RES, byte_res("x")),
      pred_row(CHAR_ZERO),
      pred_row(CHAR_CARET),
      fixed_row(CHAR_NUL, 2'd1, END_RES, NO_RES),
      pred_row("2"),
      pred_row("5"),
      pred_row("5"),
      fixed_row(CHAR_NL, 2'd2, byte_res(BYTE_MAX), END_RES)
   };

   logic clock;
   logic reset;

   esd_req_if req_bus ();
   esd_rsp_if rsp_bus ();

   escape_string_decoder_unit dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   mode_type dec_mode;
   logic [NUM_W-1:0] dec_value;
   result_type decoded_q[$];
   logic [CHAR_W-1:0] raw_text[$];
   stim_row_type cur_row;

   int send_idle_pct;
   int recv_idle_pct;
   int fail_count;
   int chars_in;
   int bytes_out;
   int strings_closed;
   int number_errors;
   int stall_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void close_string(ref result_type outq[$]);
      dec_mode = MODE_NORMAL;
      dec_value = '0;
      outq.push_back(END_RES);
   endfunction

   function automatic void decode_plain(input logic [CHAR_W-1:0] c, ref result_type outq[$]);
      if (c == CHAR_NUL || c == CHAR_NL) begin
         close_string(outq);
      end else if (c == CHAR_SPACE || c == CHAR_TAB) begin
      end else if (c == CHAR_BSLASH) begin
         dec_mode = MODE_ESCAPE;
      end else if (c == CHAR_CARET) begin
         dec_mode = MODE_CARET;
      end else if (c == CHAR_QUOTE) begin
         dec_mode = MODE_QUOTE;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         dec_mode = MODE_NUMBER;
         dec_value = NUM_W'(c - CHAR_ZERO);
      end else begin
         outq.push_back(byte_res(c));
      end
   endfunction

   function automatic void decode_char(input logic [CHAR_W-1:0] c, ref result_type outq[$]);
      int v;
      logic [CHAR_W-1:0] code;
      case (dec_mode)
         MODE_ESCAPE: begin
            if (c == CHAR_NUL) begin
               close_string(outq);
            end else begin
               dec_mode = MODE_NORMAL;
               outq.push_back(byte_res(c));
            end
         end
         MODE_CARET: begin
            if (c == CHAR_NUL) begin
               close_string(outq);
            end else begin
               dec_mode = MODE_NORMAL;
               code = c & CTRL_MASK;
               if (((c >= CHAR_AT && c <= CHAR_USCORE) || (c >= CHAR_LA && c <= CHAR_LZ))
                   && code != CHAR_NUL)
                  outq.push_back(byte_res(code));
            end
         end
         MODE_QUOTE: begin
            if (c == CHAR_NUL)
               close_string(outq);
            else if (c == CHAR_QUOTE)
               dec_mode = MODE_QCLOSE;
            else
               outq.push_back(byte_res(c));
         end
         MODE_QCLOSE: begin
            if (c == CHAR_QUOTE) begin
               dec_mode = MODE_QUOTE;
               outq.push_back(byte_res(CHAR_QUOTE));
            end else begin
               dec_mode = MODE_NORMAL;
               decode_plain(c, outq);
            end
         end
         MODE_NUMBER: begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
               v = int'(dec_value) * 10 + int'(c - CHAR_ZERO);
               dec_value = (v > int'(NUM_SAT)) ? NUM_SAT : NUM_W'(v);
            end else begin
               if (dec_value > NUM_W'(BYTE_MAX))
                  outq.push_back(ERR_RES);
               else if (dec_value != '0)
                  outq.push_back(byte_res(dec_value[CHAR_W-1:0]));
               dec_mode = MODE_NORMAL;
               dec_value = '0;
               decode_plain(c, outq);
            end
         end
         default: begin
            dec_mode = MODE_NORMAL;
            dec_value = '0;
            decode_plain(c, outq);
         end
      endcase
   endfunction

   always @(posedge clock) begin : monitor
      result_type fresh[$];
      result_type want;
      if (reset) begin
         dec_mode = MODE_NORMAL;
         dec_value = '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            chars_in++;
            fresh.delete();
            decode_char(req_bus.in_char, fresh);
            if (cur_row.typed) begin
               if (cur_row.count > 2'd0)
                  decoded_q.push_back(cur_row.r0);
               if (cur_row.count > 2'd1)
                  decoded_q.push_back(cur_row.r1);
            end else begin
               foreach (fresh[i])
                  decoded_q.push_back(fresh[i]);
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (rsp_bus.end_mark)
               strings_closed++;
            else if (rsp_bus.number_error)
               number_errors++;
            else
               bytes_out++;
            if (decoded_q.size() == 0) begin
               $error("unexpected item: out_char=%02h end_mark=%0b number_error=%0b",
                      rsp_bus.out_char, rsp_bus.end_mark, rsp_bus.number_error);
               fail_count++;
            end else begin
               want = decoded_q.pop_front();
               if (!want.end_mark && rsp_bus.out_char !== want.out_char) begin
                  $error("out_char: expected %02h, got %02h", want.out_char, rsp_bus.out_char);
                  fail_count++;
               end
               if (rsp_bus.end_mark !== want.end_mark) begin
                  $error("end_mark: expected %0b, got %0b", want.end_mark, rsp_bus.end_mark);
                  fail_count++;
               end
               if (rsp_bus.number_error !== want.number_error) begin
                  $error("number_error: expected %0b, got %0b", want.number_error,
                         rsp_bus.number_error);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
         $display("** escape_string_decoder_unit: FAILED **");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);

   task automatic send_char(input stim_row_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      cur_row = r;
      req_bus.valid <= 1'b1;
      req_bus.in_char <= r.ch;
      do
         @(posedge clock);
      while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (decoded_q.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [CHAR_W-1:0] any_char();
      return CHAR_W'($urandom_range(1, 255));
   endfunction

   function automatic void build_string();
      int n_tokens;
      int n;
      logic [CHAR_W-1:0] c;
      n_tokens = $urandom_range(1, 8);
      repeat (n_tokens) begin
         case ($urandom_range(0, 11))
            0, 1: raw_text.push_back(CHAR_W'($urandom_range(8'h21, 8'h7E)));
            2: raw_text.push_back(any_char());
            3: raw_text.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
            4: begin
               raw_text.push_back(CHAR_BSLASH);
               raw_text.push_back(($urandom_range(7) == 0) ? CHAR_NUL : any_char());
            end
            5, 6: begin
               raw_text.push_back(CHAR_CARET);
               case ($urandom_range(0, 3))
                  0: c = CHAR_W'($urandom_range(CHAR_AT, CHAR_USCORE));
                  1: c = CHAR_W'($urandom_range(CHAR_LA, CHAR_LZ));
                  2: c = any_char();
                  default: c = CHAR_AT;
               endcase
               raw_text.push_back(c);
            end
            7, 8: begin
               raw_text.push_back(CHAR_QUOTE);
               n = $urandom_range(0, 5);
               repeat (n) begin
                  c = ($urandom_range(3) == 0) ? CHAR_QUOTE : any_char();
                  raw_text.push_back(c);
                  if (c == CHAR_QUOTE)
                     raw_text.push_back(CHAR_QUOTE);
               end
               raw_text.push_back(CHAR_QUOTE);
            end
            9, 10: begin
               n = $urandom_range(1, 4);
               repeat (n)
                  raw_text.push_back(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
            end
            default: raw_text.push_back(CHAR_W'($urandom_range(0, 255)));
         endcase
      end
      n = $urandom_range(0, 99);
      if (n < 80)
         raw_text.push_back(CHAR_NL);
      else if (n < 95)
         raw_text.push_back(CHAR_NUL);
   endfunction

   task automatic run_random(input int send_pct, input int recv_pct, input int target);
      int sent;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < target) begin
         build_string();
         while (raw_text.size() != 0) begin
            send_char(pred_row(raw_text.pop_front()));
            sent++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.in_char = '0;
      rsp_bus.ready = 1'b0;
      cur_row = pred_row(CHAR_NUL);
      send_idle_pct = 24;
      recv_idle_pct = 58;
      fail_count = 0;
      chars_in = 0;
      bytes_out = 0;
      strings_closed = 0;
      number_errors = 0;
      stall_cycles = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED_ROWS[i])
         send_char(DIRECTED_ROWS[i]);
      wait_drained();

      run_random(24, 58, 140);
      wait_drained();
      run_random(58, 24, 140);
      wait_drained();
      run_random(0, 0, 140);

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d characters: directed cases, then random strings under three idling",
               chars_in);
      $display("patterns, giving %0d bytes, %0d string ends and %0d number errors.",
               bytes_out, strings_closed, number_errors);
      if (fail_count == 0 && decoded_q.size() == 0) begin
         $display("** escape_string_decoder_unit: PASSED **");
      end else begin
         $display("** escape_string_decoder_unit: FAILED **");
      end
      $finish;
   end

endmodule
